// ===== hdl/pdfsd_pkg.sv =====
// ----------------------------------------------------------------------------
// pdfsd_pkg
// Shared types and constants of the stream delimiter scanner: scan modes,
// event codes, counter width and the byte patterns looked for in the window.
// ----------------------------------------------------------------------------
package pdfsd_pkg;

    // Width of the payload byte counter (saturating).
    localparam int unsigned COUNT_BITS = 32;
    // Width of the reported payload length.
    localparam int unsigned LEN_BITS   = 32;
    // History window: ten bytes, newest byte in the lowest bits.
    localparam int unsigned WIN_BYTES  = 10;
    localparam int unsigned WIN_BITS   = WIN_BYTES * 8;

    // Bytes of delimiter trailing the payload for each end form.
    localparam logic [COUNT_BITS-1:0] END_LF_SUB = COUNT_BITS'(10);
    localparam logic [COUNT_BITS-1:0] END_CR_SUB = COUNT_BITS'(11);

    // Patterns, last byte lowest.
    localparam logic [55:0] PAT_STREAM_LF    = 56'h73_74_72_65_61_6D_0A;
    localparam logic [63:0] PAT_STREAM_CRLF  = 64'h73_74_72_65_61_6D_0D_0A;
    localparam logic [79:0] PAT_ENDSTREAM_LF = 80'h65_6E_64_73_74_72_65_61_6D_0A;
    localparam logic [79:0] PAT_ENDSTREAM_CR = 80'h65_6E_64_73_74_72_65_61_6D_0D;
    localparam logic [55:0] PAT_ENDOBJ_LF    = 56'h65_6E_64_6F_62_6A_0A;
    localparam logic [55:0] PAT_ENDOBJ_CR    = 56'h65_6E_64_6F_62_6A_0D;

    typedef enum logic [1:0] {
        MODE_SEARCH = 2'd0,
        MODE_FIRST  = 2'd1,
        MODE_SCAN   = 2'd2
    } t_mode;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_START = 2'd1,
        EV_END   = 2'd2,
        EV_ABORT = 2'd3
    } t_event;

    // Pattern hits on the window after the new byte is shifted in.
    typedef struct packed {
        logic stream_lf;
        logic stream_crlf;
        logic endstream_lf;
        logic endstream_cr;
        logic endobj_lf;
        logic endobj_cr;
    } t_match;

endpackage

// ===== hdl/pdf_stream_delimiter_scanner.sv =====
// ----------------------------------------------------------------------------
// pdf_stream_delimiter_scanner
// Byte stream scanner that finds PDF stream payloads and reports their length.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata                       | tuser           | tlast
//  ---------+-----+-----------------------------+-----------------+------------
//  s_axis   | in  | [7:0] data_byte             | -               | end_of_data
//  m_axis   | out | [31:0] payload_length       | [1:0] event_res | -
//
//  One result beat for every input beat, in order. One beat per cycle
//  sustained while m_axis takes every beat: a byte passes from the input
//  register through the pattern compares and the counter to the result
//  register, with no further register in between.
//  Reset (synchronous, active low) empties both registers and returns the
//  scan to searching with a cleared window and count.
//  A stall on m_axis holds the result; one more byte is held in the input
//  register before s_axis_tready drops.
// ----------------------------------------------------------------------------
module pdf_stream_delimiter_scanner (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input byte stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_data
    // result stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] payload_length
    output logic [1:0]  m_axis_tuser    // [1:0] event_res
);

    logic                               r_in_vld;
    logic [7:0]                         r_in_byte;
    logic                               r_in_eod;

    logic                               r_out_vld;
    pdfsd_pkg::t_event                  r_out_ev;
    logic [pdfsd_pkg::LEN_BITS-1:0]     r_out_len;

    logic                               adv;
    pdfsd_pkg::t_event                  core_ev;
    logic [pdfsd_pkg::LEN_BITS-1:0]     core_len;

    // Advance the held byte whenever the result slot is free or being emptied.
    assign adv           = r_in_vld && (!r_out_vld || m_axis_tready);
    assign s_axis_tready = !r_in_vld || adv;

    // Input register: take a new beat whenever it is empty or the held one moves on.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_vld <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_eod  <= s_axis_tlast;
        end
    end

    pdfsd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (adv),
        .i_byte  (r_in_byte),
        .i_eod   (r_in_eod),
        .o_event (core_ev),
        .o_len   (core_len)
    );

    // Result register: load on advance, drop the valid once the beat is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_ev  <= core_ev;
            r_out_len <= core_len;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = r_out_len;
    assign m_axis_tuser  = r_out_ev;

endmodule

// ===== hdl/pdfsd_match.sv =====
// ----------------------------------------------------------------------------
// pdfsd_match
// Parallel fixed-pattern compares on the tail of the history window.
// ----------------------------------------------------------------------------
module pdfsd_match (
    input  logic [pdfsd_pkg::WIN_BITS-1:0] i_win,
    output pdfsd_pkg::t_match              o_match
);

    always_comb begin
        o_match.stream_lf    = (i_win[55:0] == pdfsd_pkg::PAT_STREAM_LF);
        o_match.stream_crlf  = (i_win[63:0] == pdfsd_pkg::PAT_STREAM_CRLF);
        o_match.endstream_lf = (i_win[79:0] == pdfsd_pkg::PAT_ENDSTREAM_LF);
        o_match.endstream_cr = (i_win[79:0] == pdfsd_pkg::PAT_ENDSTREAM_CR);
        o_match.endobj_lf    = (i_win[55:0] == pdfsd_pkg::PAT_ENDOBJ_LF);
        o_match.endobj_cr    = (i_win[55:0] == pdfsd_pkg::PAT_ENDOBJ_CR);
    end

endmodule

// ===== hdl/pdfsd_core.sv =====
// ----------------------------------------------------------------------------
// pdfsd_core
// Scan state, history window and payload counter; works out the event and
// length of one byte and advances the state when the byte moves on.
// ----------------------------------------------------------------------------
module pdfsd_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_adv,
    input  logic [7:0]                      i_byte,
    input  logic                            i_eod,
    output pdfsd_pkg::t_event               o_event,
    output logic [pdfsd_pkg::LEN_BITS-1:0]  o_len
);

    localparam int unsigned CB = pdfsd_pkg::COUNT_BITS;
    localparam int unsigned LB = pdfsd_pkg::LEN_BITS;

    pdfsd_pkg::t_mode                    r_mode, n_mode;
    logic [pdfsd_pkg::WIN_BITS-1:0]      r_win,  n_win;
    logic [CB-1:0]                       r_cnt,  n_cnt;

    logic [pdfsd_pkg::WIN_BITS-1:0]      w_shift;
    logic [CB-1:0]                       cnt_inc;
    pdfsd_pkg::t_match                   hit;
    logic                                start_hit;
    logic                                abort_hit;

    // Count minus the delimiter length, clamped at zero and at the length width.
    function automatic logic [LB-1:0] sat_len(input logic [CB-1:0] cnt,
                                              input logic [CB-1:0] sub);
        logic [CB-1:0] diff;
        diff = (cnt > sub) ? (cnt - sub) : '0;
        if ((diff >> LB) != '0) begin
            sat_len = '1;
        end else begin
            sat_len = LB'(diff);
        end
    endfunction

    assign w_shift = {r_win[pdfsd_pkg::WIN_BITS-9:0], i_byte};
    assign cnt_inc = (r_cnt != '1) ? (r_cnt + CB'(1)) : r_cnt;

    pdfsd_match u_match (
        .i_win   (w_shift),
        .o_match (hit)
    );

    assign start_hit = (hit.stream_lf || hit.stream_crlf) &&
                       !hit.endstream_lf && !hit.endstream_cr;
    assign abort_hit = hit.endobj_lf || hit.endobj_cr ||
                       (hit.stream_lf && !hit.endstream_lf) ||
                       (hit.stream_crlf && !hit.endstream_cr);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= pdfsd_pkg::MODE_SEARCH;
            r_win  <= '0;
            r_cnt  <= '0;
        end else if (i_adv) begin
            r_mode <= n_mode;
            r_win  <= n_win;
            r_cnt  <= n_cnt;
        end
    end

    always_comb begin
        n_mode  = r_mode;
        n_win   = r_win;
        n_cnt   = r_cnt;
        o_event = pdfsd_pkg::EV_NONE;
        o_len   = '0;
        unique case (r_mode) inside
            pdfsd_pkg::MODE_FIRST, pdfsd_pkg::MODE_SCAN: begin
                if (i_eod) begin
                    o_event = pdfsd_pkg::EV_ABORT;
                    n_mode  = pdfsd_pkg::MODE_SEARCH;
                    n_win   = '0;
                    n_cnt   = '0;
                end else if (r_mode == pdfsd_pkg::MODE_FIRST) begin
                    // first payload byte: neither shifted in nor counted
                    n_mode = pdfsd_pkg::MODE_SCAN;
                    n_cnt  = '0;
                end else begin
                    n_win = w_shift;
                    n_cnt = cnt_inc;
                    if (abort_hit || hit.endstream_lf || hit.endstream_cr) begin
                        n_mode = pdfsd_pkg::MODE_SEARCH;
                        n_win  = '0;
                        n_cnt  = '0;
                    end
                    if (abort_hit) begin
                        o_event = pdfsd_pkg::EV_ABORT;
                    end else if (hit.endstream_lf) begin
                        o_event = pdfsd_pkg::EV_END;
                        o_len   = sat_len(cnt_inc, pdfsd_pkg::END_LF_SUB);
                    end else if (hit.endstream_cr) begin
                        o_event = pdfsd_pkg::EV_END;
                        o_len   = sat_len(cnt_inc, pdfsd_pkg::END_CR_SUB);
                    end
                end
            end
            default: begin
                // searching, and the unused mode code treated the same
                n_mode = pdfsd_pkg::MODE_SEARCH;
                if (i_eod) begin
                    n_win = '0;
                    n_cnt = '0;
                end else if (start_hit) begin
                    o_event = pdfsd_pkg::EV_START;
                    n_mode  = pdfsd_pkg::MODE_FIRST;
                    n_win   = '0;
                    n_cnt   = '0;
                end else begin
                    n_win = w_shift;
                end
            end
        endcase
    end

endmodule

// ===== hdl/pdfsd_checker.sv =====
// ----------------------------------------------------------------------------
// pdfsd_checker
// Port-level checks of the stream delimiter scanner, bound to the top level.
// ----------------------------------------------------------------------------
module pdfsd_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tready,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,
    input  logic [1:0]  i_m_tuser
);

    logic r_prev_start;

    // Remember whether the last delivered beat was a stream start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_start <= 1'b0;
        end else if (i_m_tvalid && i_m_tready) begin
            r_prev_start <= (i_m_tuser == pdfsd_pkg::EV_START);
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tuser))
        else $error("result beat changed while stalled");

    a_len_only_on_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && (i_m_tuser != pdfsd_pkg::EV_END) |-> (i_m_tdata == '0))
        else $error("non-zero length on a beat that is not a stream end");

    a_after_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && r_prev_start |->
            (i_m_tuser == pdfsd_pkg::EV_NONE) || (i_m_tuser == pdfsd_pkg::EV_ABORT))
        else $error("first payload byte gave a start or end event");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> i_s_tready && !i_m_tvalid)
        else $error("block not empty after reset");

endmodule

bind pdf_stream_delimiter_scanner pdfsd_checker u_pdfsd_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tready (s_axis_tready),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tuser  (m_axis_tuser)
);

// ===== verif/pdfsd_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pdfsd_event_checker
// Watches both streams of the delimiter scanner. It runs its own copy of the
// window, mode and count on every accepted byte and holds the expected
// event and length. Each result beat is compared with the oldest one held.
// ----------------------------------------------------------------------------
module pdfsd_event_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
    input  logic        s_axis_tlast,   // end_of_data
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [31:0] m_axis_tdata,   // [31:0] payload_length
    input  logic [1:0]  m_axis_tuser,   // [1:0] event_res
    output int          o_fail_count,
    output int          o_pending,
    output int          o_starts,
    output int          o_ends,
    output int          o_aborts
);

    // Keywords, last byte in the lowest bits, as they sit in the window.
    localparam logic [55:0] KW_STREAM_LF    = {"stream", 8'h0A};
    localparam logic [63:0] KW_STREAM_CRLF  = {"stream", 8'h0D, 8'h0A};
    localparam logic [79:0] KW_ENDSTREAM_LF = {"endstream", 8'h0A};
    localparam logic [79:0] KW_ENDSTREAM_CR = {"endstream", 8'h0D};
    localparam logic [55:0] KW_ENDOBJ_LF    = {"endobj", 8'h0A};
    localparam logic [55:0] KW_ENDOBJ_CR    = {"endobj", 8'h0D};
    // Delimiter bytes counted after the payload for each end form.
    localparam logic [31:0] TRAIL_LF = 32'd10;
    localparam logic [31:0] TRAIL_CR = 32'd11;

    typedef struct {
        pdfsd_pkg::t_event ev;
        logic [31:0]       len;
    } t_scan_result;

    pdfsd_pkg::t_mode scan_mode;
    logic [79:0]      window;
    logic [31:0]      payload_count;
    t_scan_result     expected_events[$];

    function automatic void clear_scan();
        scan_mode     = pdfsd_pkg::MODE_SEARCH;
        window        = '0;
        payload_count = '0;
    endfunction

    // Advance the scanner by one byte (or end-of-data mark) and return its event.
    function automatic t_scan_result scan_byte(input logic [7:0] b, input logic eod);
        t_scan_result r;
        logic es_lf;
        logic es_cr;
        logic cut;
        r.ev  = pdfsd_pkg::EV_NONE;
        r.len = '0;
        if (scan_mode == pdfsd_pkg::MODE_FIRST || scan_mode == pdfsd_pkg::MODE_SCAN) begin
            if (eod) begin
                r.ev = pdfsd_pkg::EV_ABORT;
                clear_scan();
            end else if (scan_mode == pdfsd_pkg::MODE_FIRST) begin
                // first payload byte: neither shifted in nor counted
                scan_mode     = pdfsd_pkg::MODE_SCAN;
                payload_count = '0;
            end else begin
                window = {window[71:0], b};
                if (payload_count != '1)
                    payload_count = payload_count + 1'b1;
                es_lf = (window == KW_ENDSTREAM_LF);
                es_cr = (window == KW_ENDSTREAM_CR);
                cut   = (window[55:0] == KW_ENDOBJ_LF) || (window[55:0] == KW_ENDOBJ_CR) ||
                        ((window[55:0] == KW_STREAM_LF) && !es_lf) ||
                        ((window[63:0] == KW_STREAM_CRLF) && !es_cr);
                if (cut) begin
                    r.ev = pdfsd_pkg::EV_ABORT;
                    clear_scan();
                end else if (es_lf) begin
                    r.ev  = pdfsd_pkg::EV_END;
                    r.len = (payload_count > TRAIL_LF) ? payload_count - TRAIL_LF : '0;
                    clear_scan();
                end else if (es_cr) begin
                    r.ev  = pdfsd_pkg::EV_END;
                    r.len = (payload_count > TRAIL_CR) ? payload_count - TRAIL_CR : '0;
                    clear_scan();
                end
            end
        end else begin
            if (eod) begin
                clear_scan();
            end else begin
                window = {window[71:0], b};
                if (((window[55:0] == KW_STREAM_LF) || (window[63:0] == KW_STREAM_CRLF)) &&
                    (window != KW_ENDSTREAM_LF) && (window != KW_ENDSTREAM_CR)) begin
                    r.ev = pdfsd_pkg::EV_START;
                    clear_scan();
                    scan_mode = pdfsd_pkg::MODE_FIRST;
                end else begin
                    scan_mode = pdfsd_pkg::MODE_SEARCH;
                end
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_scan_result want;
        if (!i_rst_n) begin
            clear_scan();
            expected_events.delete();
            o_fail_count <= 0;
            o_pending    <= 0;
            o_starts     <= 0;
            o_ends       <= 0;
            o_aborts     <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready)
                expected_events.push_back(scan_byte(s_axis_tdata, s_axis_tlast));
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_events.size() == 0) begin
                    $error("result beat with nothing expected: event_res %0d, payload_length %0d",
                           m_axis_tuser, m_axis_tdata);
                    o_fail_count <= o_fail_count + 1;
                end else begin
                    want = expected_events.pop_front();
                    if (m_axis_tuser !== want.ev) begin
                        $error("event_res mismatch: expected %0d, actual %0d",
                               want.ev, m_axis_tuser);
                        o_fail_count <= o_fail_count + 1;
                    end else if (m_axis_tdata !== want.len) begin
                        $error("payload_length mismatch: expected %0d, actual %0d",
                               want.len, m_axis_tdata);
                        o_fail_count <= o_fail_count + 1;
                    end
                    case (want.ev)
                        pdfsd_pkg::EV_START: o_starts <= o_starts + 1;
                        pdfsd_pkg::EV_END:   o_ends   <= o_ends + 1;
                        pdfsd_pkg::EV_ABORT: o_aborts <= o_aborts + 1;
                        default: ;
                    endcase
                end
            end
            o_pending <= expected_events.size();
        end
    end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the stream delimiter scanner. Feeds documents
// built from stream openers, payloads, closers, object ends and noise,
// with varied pacing on both sides; the checker does the comparing.
// ----------------------------------------------------------------------------
module tb;

    // Cycles without any accepted beat before the run is declared hung.
    localparam int STALL_LIMIT = 2000;
    localparam logic [7:0] LF = 8'h0A;
    localparam logic [7:0] CR = 8'h0D;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;   // [7:0] data_byte
    logic        s_axis_tlast;   // end_of_data
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;   // [31:0] payload_length
    logic [1:0]  m_axis_tuser;   // [1:0] event_res

    int fail_count;
    int pending;
    int starts;
    int ends;
    int aborts;
    int beats_sent;
    int drains;
    int src_idle_pct;
    int snk_idle_pct;
    int quiet_cycles;

    pdf_stream_delimiter_scanner DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    pdfsd_event_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_starts      (starts),
        .o_ends        (ends),
        .o_aborts      (aborts)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Receiver: drop tready at random, at the rate of the current phase.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= snk_idle_pct);
    end

    // Watchdog: count cycles in which neither channel moves a beat.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("pdf_stream_delimiter_scanner verification failed");
            $finish;
        end
    end

    // Offer one beat and hold it until the scanner takes it. Called and left
    // at a falling edge, so tvalid gets one assignment per step.
    task automatic push_beat(input logic [7:0] b, input logic eod);
        while ($urandom_range(99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eod;
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        beats_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_beat(s[i], 1'b0);
    endtask

    // Bytes drawn half from the keyword alphabet, so near misses are common.
    function automatic logic [7:0] noise_byte();
        logic [7:0] b;
        case ($urandom_range(25))
            0:  b = "s";
            1:  b = "t";
            2:  b = "r";
            3:  b = "e";
            4:  b = "a";
            5:  b = "m";
            6:  b = "n";
            7:  b = "d";
            8:  b = "o";
            9:  b = "b";
            10: b = "j";
            11: b = CR;
            12: b = LF;
            default: b = 8'($urandom_range(255));
        endcase
        return b;
    endfunction

    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++)
            push_beat(noise_byte(), 1'b0);
    endtask

    // "stream" with either terminator: LF or CR LF.
    task automatic open_stream();
        send_text("stream");
        if ($urandom_range(1))
            push_beat(CR, 1'b0);
        push_beat(LF, 1'b0);
    endtask

    task automatic close_stream();
        send_text("endstream");
        push_beat($urandom_range(1) ? LF : CR, 1'b0);
    endtask

    // Mostly short payloads; now and then a long one.
    function automatic int payload_size();
        return ($urandom_range(29) == 0) ? $urandom_range(400, 200) : $urandom_range(24);
    endfunction

    // Hold the sender off until every expected result has come back.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0)
            @(negedge i_clk);
        drains++;
    endtask

    task automatic run_phase(input int n_beats, input int src_pct, input int snk_pct);
        int first_beat;
        int pick;
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        first_beat   = beats_sent;
        while (beats_sent - first_beat < n_beats) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                // well-formed stream: opener, payload, closer
                send_noise($urandom_range(4));
                open_stream();
                push_beat(8'($urandom_range(255)), 1'b0);
                send_noise(payload_size());
                close_stream();
            end else if (pick < 65) begin
                // object ends inside the payload
                open_stream();
                push_beat(8'($urandom_range(255)), 1'b0);
                send_noise(payload_size());
                send_text("endobj");
                push_beat($urandom_range(1) ? LF : CR, 1'b0);
            end else if (pick < 73) begin
                // second opener inside the payload
                open_stream();
                push_beat(8'($urandom_range(255)), 1'b0);
                send_noise(payload_size());
                open_stream();
            end else if (pick < 81) begin
                // data ends while awaiting the first byte or mid-payload
                open_stream();
                if ($urandom_range(1)) begin
                    push_beat(8'($urandom_range(255)), 1'b0);
                    send_noise(payload_size());
                end
                push_beat(8'($urandom_range(255)), 1'b1);
            end else if (pick < 89) begin
                // closer while searching: opens no stream with LF or CR, but does with CR LF
                send_text("endstream");
                case ($urandom_range(2))
                    0: push_beat(LF, 1'b0);
                    1: push_beat(CR, 1'b0);
                    default: begin
                        push_beat(CR, 1'b0);
                        push_beat(LF, 1'b0);
                    end
                endcase
            end else begin
                // noise with scattered end-of-data marks
                repeat ($urandom_range(12, 1))
                    push_beat(noise_byte(), ($urandom_range(7) == 0));
            end
            if ($urandom_range(39) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial begin
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        src_idle_pct  = 0;
        snk_idle_pct  = 0;
        beats_sent    = 0;
        drains        = 0;
        quiet_cycles  = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: end of data while searching, extreme byte values,
        // both openers, end of data while awaiting the first byte,
        // and an object end cutting a payload.
        push_beat(8'hA5, 1'b1);
        push_beat(8'hFF, 1'b0);
        send_text("stream");
        push_beat(CR, 1'b0);
        push_beat(LF, 1'b0);
        push_beat(8'h00, 1'b1);
        send_text("stream");
        push_beat(LF, 1'b0);
        push_beat(8'hFF, 1'b0);
        send_text("endobj");
        push_beat(CR, 1'b0);
        drain_results();

        // Random: slow receiver, slow sender, then full rate.
        run_phase(200, 36, 74);
        run_phase(200, 74, 36);
        run_phase(190, 0, 0);

        // Let the pipeline settle before the verdict.
        repeat (8) @(posedge i_clk);
        $display("covered %0d input beats: %0d stream starts, %0d ends, %0d aborts",
                 beats_sent, starts, ends, aborts);
        $display("three pacing phases with %0d full drains of the result stream", drains);
        if (fail_count == 0)
            $display("pdf_stream_delimiter_scanner verification clean");
        else
            $display("pdf_stream_delimiter_scanner verification failed");
        $finish;
    end

endmodule
